FILE: sv/brac_pkg.sv
// Shared types and constants for the bit-sliced row-AND and hit-count core.
// Holds the transaction structs, operation codes and register indexes.
// No dependencies; compiled first.
package brac_pkg;

    // Default sizes, handed to the top level as parameter defaults
    localparam int MAX_HASHES_DEF = 8;
    localparam int ROW_WORDS_DEF  = 16;
    localparam int NUM_DOCS_DEF   = 1024;

    // Lanes per row word and counter width
    localparam int LANES   = 64;
    localparam int CNT_W   = 16;
    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Operation codes
    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ROW   = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Configuration register indexes and reset values
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 5;
    localparam logic [CFG_IDX_W-1:0] REG_HASHES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORDS  = 1'd1;
    localparam logic [3:0] HASHES_RESET = 4'd1;
    localparam logic [4:0] WORDS_RESET  = 5'd16;

    // Input transaction
    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  word_index;
        logic [2:0]  hash_index;
        logic [63:0] row_word;
        logic [9:0]  doc_index;
    } t_in_item;

    // Result transaction
    typedef struct packed {
        logic [9:0]  doc_index_out;
        logic [15:0] hit_count;
    } t_out_item;

    // One memory row: the counters of 64 documents
    typedef logic [LANES-1:0][CNT_W-1:0] t_cnt_row;

    // Stage-1 command to the counter bank
    typedef struct packed {
        logic              clear;
        logic              inc;
        logic [LANES-1:0]  bits;
    } t_cnt_cmd;

endpackage

FILE: sv/brac_counter_bank.sv
// Hit counter memory: one row of 64 saturating 16-bit counters per row word.
// Row valid bits give a clear of all rows; a write-back register forwards the
// last written row. Depends on brac_pkg.
module brac_counter_bank #(
    parameter int NUM_DOCS = brac_pkg::NUM_DOCS_DEF,
    parameter int CNT_AW   = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [3:0]         i_rd_row,
    input  brac_pkg::t_cnt_cmd i_cmd,
    output brac_pkg::t_cnt_row o_row
);
    import brac_pkg::*;

    localparam int CNT_DEPTH = 2 ** CNT_AW;

    t_cnt_row               r_mem [CNT_DEPTH];
    t_cnt_row               r_rd_data;
    logic [3:0]             r_row;
    logic [CNT_DEPTH-1:0]   r_row_valid;
    logic                   r_wb_valid;
    logic [CNT_AW-1:0]      r_wb_row;
    t_cnt_row               r_wb_data;

    logic [CNT_AW-1:0]      addr;
    t_cnt_row               cur;
    t_cnt_row               n_row;
    logic [LANES-1:0]       lane_ok;

    assign addr = r_row[CNT_AW-1:0];

    // Pick the current row: forwarded write, memory data, or zero if cleared
    always_comb begin
        if (r_wb_valid && (r_wb_row == addr)) begin
            cur = r_wb_data;
        end else if (r_row_valid[addr]) begin
            cur = r_rd_data;
        end else begin
            cur = '0;
        end
    end

    // Drop lanes whose document lies beyond the last one
    always_comb begin
        for (int b = 0; b < LANES; b++) begin
            lane_ok[b] = (17'({r_row, 6'(b)}) < 17'(NUM_DOCS));
        end
    end

    // Saturating increment of every lane whose bit is set
    always_comb begin
        for (int b = 0; b < LANES; b++) begin
            if (i_cmd.bits[b] && lane_ok[b] && (cur[b] != COUNT_MAX)) begin
                n_row[b] = cur[b] + 16'd1;
            end else begin
                n_row[b] = cur[b];
            end
        end
    end

    assign o_row = cur;

    // Memory: registered read, write back in stage 1
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row[CNT_AW-1:0]];
            r_row     <= i_rd_row;
        end
        if (i_cmd.inc) begin
            r_mem[addr] <= n_row;
        end
    end

    // Forwarding payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.inc) begin
            r_wb_row  <= addr;
            r_wb_data <= n_row;
        end
    end

    // Valid bits and forwarding flag; clear drops both
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_wb_valid  <= 1'b0;
        end else if (i_cmd.clear) begin
            r_row_valid <= '0;
            r_wb_valid  <= 1'b0;
        end else if (i_cmd.inc) begin
            r_row_valid[addr] <= 1'b1;
            r_wb_valid        <= 1'b1;
        end
    end

endmodule

FILE: sv/bitsliced_row_and_count.sv
// Top level of the bit-sliced row-AND and hit-count core.
// Holds config registers, the AND accumulator memory and the stage-1 control.
// Depends on brac_pkg and brac_counter_bank.
//
//  channel   | signals                                   | direction
//  ----------+-------------------------------------------+----------
//  command   | start, busy, i_item                       | in, busy out
//  result    | o_result_valid, o_result                  | out
//  config    | i_cfg_valid, o_cfg_ready, i_cfg_index,    | in, o_cfg_ready out
//            | i_cfg_data                                |
//
// One transaction is accepted every cycle; busy stays low. A transaction is
// read from the accumulator and counter memories at the accept edge, modified
// and written back in the next cycle; a read result appears on o_result in the
// cycle after that, for one cycle. A clear acts through the counter row valid
// bits. Reset loads the config defaults and clears valid bits and pipeline
// control; the accumulator is undefined until loaded. The receiver cannot stall.
module bitsliced_row_and_count #(
    parameter int MAX_HASHES = brac_pkg::MAX_HASHES_DEF,
    parameter int ROW_WORDS  = brac_pkg::ROW_WORDS_DEF,
    parameter int NUM_DOCS   = brac_pkg::NUM_DOCS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  brac_pkg::t_in_item                  i_item,
    output logic                                o_result_valid,
    output brac_pkg::t_out_item                 o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [brac_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [brac_pkg::CFG_DAT_W-1:0]      i_cfg_data
);
    import brac_pkg::*;

    localparam int ACC_DEPTH = (ROW_WORDS < 16) ? ROW_WORDS : 16;
    localparam int ACC_AW    = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
    localparam int CNT_ROWS_RAW = (NUM_DOCS + LANES - 1) / LANES;
    localparam int CNT_ROWS  = (CNT_ROWS_RAW < 16) ? CNT_ROWS_RAW : 16;
    localparam int CNT_AW    = (CNT_ROWS > 1) ? $clog2(CNT_ROWS) : 1;

    logic [3:0]         r_hashes;
    logic [4:0]         r_words;

    logic               r_s1_valid;
    t_in_item           r_s1_item;

    logic [63:0]        r_acc_mem [2 ** ACC_AW];
    logic [63:0]        r_acc_rd;
    logic               r_acc_wb_valid;
    logic [ACC_AW-1:0]  r_acc_wb_row;
    logic [63:0]        r_acc_wb_data;

    logic               r_result_valid;
    t_out_item          r_result;

    logic               accept;
    logic [6:0]         eff_hashes;
    logic [10:0]        eff_words;
    logic [ACC_AW-1:0]  acc_addr;
    logic [63:0]        acc_old;
    logic [63:0]        n_acc;
    logic               row_take;
    logic               row_last;
    logic               doc_ok;
    t_cnt_cmd           cnt_cmd;
    t_cnt_row           cnt_row;
    logic [3:0]         cnt_rd_row;

    assign accept      = start && !busy;
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hashes <= HASHES_RESET;
            r_words  <= WORDS_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HASHES: r_hashes <= i_cfg_data[3:0];
                REG_WORDS:  r_words  <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Clamp the hash and word counts
    always_comb begin
        if (r_hashes == 4'd0) begin
            eff_hashes = 7'd1;
        end else if ({3'b0, r_hashes} > 7'(MAX_HASHES)) begin
            eff_hashes = 7'(MAX_HASHES);
        end else begin
            eff_hashes = {3'b0, r_hashes};
        end
        if ({6'b0, r_words} > 11'(ROW_WORDS)) begin
            eff_words = 11'(ROW_WORDS);
        end else begin
            eff_words = {6'b0, r_words};
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_item;
        end
    end

    // Accumulator memory: read at accept, write back in stage 1
    assign acc_addr = r_s1_item.word_index[ACC_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_acc_rd <= r_acc_mem[i_item.word_index[ACC_AW-1:0]];
        end
        if (row_take) begin
            r_acc_mem[acc_addr] <= n_acc;
            r_acc_wb_row        <= acc_addr;
            r_acc_wb_data       <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_wb_valid <= 1'b0;
        end else if (row_take) begin
            r_acc_wb_valid <= 1'b1;
        end
    end

    // Decide whether the row word counts, then load it (hash 0) or AND it in
    always_comb begin
        row_take = r_s1_valid && (r_s1_item.operation == OP_ROW)
                   && ({7'b0, r_s1_item.word_index} < eff_words)
                   && ({4'b0, r_s1_item.hash_index} < eff_hashes);
        row_last = ({4'b0, r_s1_item.hash_index} == (eff_hashes - 7'd1));
        if (r_acc_wb_valid && (r_acc_wb_row == acc_addr)) begin
            acc_old = r_acc_wb_data;
        end else begin
            acc_old = r_acc_rd;
        end
        if (r_s1_item.hash_index == 3'd0) begin
            n_acc = r_s1_item.row_word;
        end else begin
            n_acc = acc_old & r_s1_item.row_word;
        end
    end

    // Counter bank: read row at accept, update or clear in stage 1
    assign cnt_rd_row = (i_item.operation == OP_READ) ? i_item.doc_index[9:6]
                                                      : i_item.word_index;

    always_comb begin
        cnt_cmd.clear = r_s1_valid && (r_s1_item.operation == OP_CLEAR);
        cnt_cmd.inc   = row_take && row_last;
        cnt_cmd.bits  = n_acc;
    end

    brac_counter_bank #(
        .NUM_DOCS (NUM_DOCS),
        .CNT_AW   (CNT_AW)
    ) u_bank (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (accept),
        .i_rd_row (cnt_rd_row),
        .i_cmd    (cnt_cmd),
        .o_row    (cnt_row)
    );

    // Register the read result
    assign doc_ok = (17'(r_s1_item.doc_index) < 17'(NUM_DOCS));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= r_s1_valid && (r_s1_item.operation == OP_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && (r_s1_item.operation == OP_READ)) begin
            r_result.doc_index_out <= r_s1_item.doc_index;
            r_result.hit_count     <= doc_ok ? cnt_row[r_s1_item.doc_index[5:0]] : 16'd0;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

endmodule
